// ===== src/mmx_pkg.sv =====
package mmx_pkg;

    localparam int COEF_REGS      = 6;
    localparam int MAX_MOTORS_DEF = 6;

    localparam int CMD_W      = 16;
    localparam int COEF_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 33;
    localparam int COUNT_W    = 3;
    localparam int MIDX_W     = 3;
    localparam int SUM_W      = 20;
    localparam int ACC_W      = 34;
    localparam int PROD_W     = 32;
    localparam int FRAC_W     = 14;
    localparam int LEVEL_W    = 15;
    localparam int DIV_STEPS  = 15;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    localparam int IN_TDATA_W  = 4 * CMD_W;
    localparam int OUT_FIELD_W = MIDX_W + LEVEL_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam logic [SUM_W-1:0]   FULL_LEVEL    = SUM_W'(16384);
    localparam logic [COUNT_W-1:0] MOTOR_COUNT_RST = COUNT_W'(4);

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_FIRST = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_LAST  = CFG_IDX_W'(COEF_REGS);

    typedef struct packed {
        logic              start;
        logic              mul_p;
        logic              mul_r;
        logic              acc;
        logic              store;
        logic              load;
        logic              div_step;
        logic              emit;
        logic              last;
        logic [MIDX_W-1:0] idx;
    } t_dp_cmd;

    typedef struct packed {
        logic [COUNT_W-1:0] active;
        logic               scale;
        logic               out_free;
    } t_dp_sts;

endpackage

// ===== src/mmx_ctrl.sv =====
module mmx_ctrl
    import mmx_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_axis_tvalid,
    output logic    o_s_axis_tready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_MULP  = 8'b0000_0010,
        S_MULR  = 8'b0000_0100,
        S_ACC   = 8'b0000_1000,
        S_STORE = 8'b0001_0000,
        S_LOAD  = 8'b0010_0000,
        S_DIV   = 8'b0100_0000,
        S_EMIT  = 8'b1000_0000
    } t_state;

    t_state              r_state, n_state;
    logic [MIDX_W-1:0]   r_idx, n_idx;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                is_last;

    assign is_last = (({1'b0, r_idx} + (MIDX_W+1)'(1)) == {1'b0, i_sts.active});
    assign o_s_axis_tready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_step  = r_step;
        o_cmd      = '0;
        o_cmd.idx  = r_idx;
        o_cmd.last = is_last;
        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    o_cmd.start = 1'b1;
                    n_idx = '0;
                    if (i_sts.active != '0) begin
                        n_state = S_MULP;
                    end
                end
            end
            S_MULP: begin
                o_cmd.mul_p = 1'b1;
                n_state = S_MULR;
            end
            S_MULR: begin
                o_cmd.mul_r = 1'b1;
                n_state = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state = S_STORE;
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                if (is_last) begin
                    n_idx = '0;
                    n_state = S_LOAD;
                end else begin
                    n_idx = r_idx + MIDX_W'(1);
                    n_state = S_MULP;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_step = '0;
                n_state = i_sts.scale ? S_DIV : S_EMIT;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                // hold until the output register can take the beat
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (is_last) begin
                        n_idx = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + MIDX_W'(1);
                        n_state = S_LOAD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_step  <= n_step;
        end
    end

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_idx < i_sts.active))
        else $error("motor index beyond active count");

    a_last_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && o_cmd.last) |=> o_s_axis_tready)
        else $error("not ready after final beat");

endmodule

// ===== src/mmx_dp.sv =====
module mmx_dp
    import mmx_pkg::*;
#(
    parameter int MAX_MOTORS = MAX_MOTORS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic                   o_m_axis_tlast,
    input  t_dp_cmd                i_cmd,
    output t_dp_sts                o_sts
);

    localparam int SUM_DEPTH = (MAX_MOTORS < COEF_REGS) ? MAX_MOTORS : COEF_REGS;
    localparam int RIDX_W    = (SUM_DEPTH > 1) ? $clog2(SUM_DEPTH) : 1;

    logic [COUNT_W-1:0]    r_motor_count;
    logic [CFG_DATA_W-1:0] r_coeffs [COEF_REGS];

    logic signed [CMD_W-1:0]  r_thrust, r_pitch, r_roll, r_yaw;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic [SUM_W-1:0]         r_raw [SUM_DEPTH];
    logic [SUM_W-1:0]         r_peak;
    logic [SUM_W-1:0]         r_rem;
    logic [LEVEL_W-1:0]       r_q;

    logic                     r_out_valid;
    logic [OUT_TDATA_W-1:0]   r_out_data;
    logic                     r_out_last;

    logic [CFG_DATA_W-1:0]    coef_sel;
    logic signed [COEF_W-1:0] cp, cr;
    logic signed [CMD_W:0]    ty;
    logic signed [ACC_W-1:0]  acc_base;
    logic [SUM_W-1:0]         clamped;
    logic [SUM_W-1:0]         raw_sel;
    logic [SUM_W:0]           trial, diff;
    logic                     ge;

    assign o_cfg_ready = 1'b1;

    // active motor count, saturated to what the sum store holds
    assign o_sts.active   = (int'(r_motor_count) > SUM_DEPTH) ? COUNT_W'(SUM_DEPTH)
                                                               : r_motor_count;
    assign o_sts.scale    = (r_peak > FULL_LEVEL);
    assign o_sts.out_free = !r_out_valid || i_m_axis_tready;

    always_comb begin
        coef_sel = '0;
        if (i_cmd.idx < MIDX_W'(COEF_REGS)) begin
            coef_sel = r_coeffs[i_cmd.idx];
        end
    end

    assign cp = signed'(coef_sel[COEF_W-1:0]);
    assign cr = signed'(coef_sel[2*COEF_W-1:COEF_W]);
    assign ty = coef_sel[2*COEF_W] ? ((CMD_W+1)'(r_thrust) - (CMD_W+1)'(r_yaw))
                                   : ((CMD_W+1)'(r_thrust) + (CMD_W+1)'(r_yaw));
    assign acc_base = {{(ACC_W-CMD_W-1-FRAC_W){ty[CMD_W]}}, ty, {FRAC_W{1'b0}}};

    assign clamped = r_acc[ACC_W-1] ? '0 : r_acc[FRAC_W +: SUM_W];
    assign raw_sel = r_raw[i_cmd.idx[RIDX_W-1:0]];

    // one restoring step: the dividend bits come out of the top of r_q
    assign trial = {r_rem, r_q[LEVEL_W-1]};
    assign diff  = trial - {1'b0, r_peak};
    assign ge    = (trial >= {1'b0, r_peak});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motor_count <= MOTOR_COUNT_RST;
            for (int i = 0; i < COEF_REGS; i++) begin
                r_coeffs[i] <= '0;
            end
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_MOTOR_COUNT) begin
                r_motor_count <= i_cfg_data[COUNT_W-1:0];
            end else if (i_cfg_index >= CFG_COEFF_FIRST && i_cfg_index <= CFG_COEFF_LAST) begin
                r_coeffs[i_cfg_index - CFG_COEFF_FIRST] <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_thrust <= signed'(i_s_axis_tdata[0*CMD_W +: CMD_W]);
            r_pitch  <= signed'(i_s_axis_tdata[1*CMD_W +: CMD_W]);
            r_roll   <= signed'(i_s_axis_tdata[2*CMD_W +: CMD_W]);
            r_yaw    <= signed'(i_s_axis_tdata[3*CMD_W +: CMD_W]);
        end
        if (i_cmd.mul_p) begin
            r_prod <= r_pitch * cp;
            r_acc  <= acc_base;
        end
        if (i_cmd.mul_r) begin
            r_prod <= r_roll * cr;
            r_acc  <= r_acc + ACC_W'(r_prod);
        end
        if (i_cmd.acc) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        if (i_cmd.store) begin
            r_raw[i_cmd.idx[RIDX_W-1:0]] <= clamped;
        end
        if (i_cmd.load) begin
            r_rem <= raw_sel >> 1;
            r_q   <= o_sts.scale ? {raw_sel[0], {(LEVEL_W-1){1'b0}}} : raw_sel[LEVEL_W-1:0];
        end
        if (i_cmd.div_step) begin
            r_rem <= ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
            r_q   <= {r_q[LEVEL_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak <= '0;
        end else if (i_cmd.start) begin
            r_peak <= '0;
        end else if (i_cmd.store && (clamped > r_peak)) begin
            r_peak <= clamped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data <= {{(OUT_TDATA_W-OUT_FIELD_W){1'b0}}, r_q, i_cmd.idx};
            r_out_last <= i_cmd.last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

    a_level_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[MIDX_W +: LEVEL_W] <= FULL_LEVEL[LEVEL_W-1:0]))
        else $error("motor level above full drive");

    a_rem_below_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_rem < r_peak))
        else $error("divider remainder not below divisor");

    a_peak_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> (raw_sel <= r_peak))
        else $error("stored sum above peak");

endmodule

// ===== src/multirotor_motor_mixer_unit.sv =====
// an accepted command runs through the sums of all active motors before its first beat,
//   and through the divider as well when the peak sum exceeds full drive
// a new command is taken only after the final beat of the previous one is emitted, which an
//   output stall delays; two 16x16 products and two adds take four steps per motor, and
//   the divider gives one quotient bit per cycle, fifteen per motor
// reset: synchronous active low; motor count returns to 4, coefficients and peak to zero
module multirotor_motor_mixer_unit
    import mmx_pkg::*;
#(
    parameter int MAX_MOTORS = MAX_MOTORS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,   // thrust_cmd, pitch_cmd, roll_cmd, yaw_cmd
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,   // motor_index, motor_level, zero pad
    output logic                   o_m_axis_tlast
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    mmx_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_sts           (sts),
        .o_cmd           (cmd)
    );

    mmx_dp #(
        .MAX_MOTORS (MAX_MOTORS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cmd           (cmd),
        .o_sts           (sts)
    );

endmodule
